[sv/derq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package derq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int DISK_UNITS  = 2;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = LEN_W + 1;
    localparam int UNIT_W = (DISK_UNITS > 1) ? $clog2(DISK_UNITS) : 1;

    // command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // one stored request
    typedef struct packed {
        logic [7:0] tag;
        logic       is_write;
        logic [9:0] track;
        logic [3:0] sector;
        logic [7:0] count;
    } entry_t;

    // physical slot of a logical queue position, circular within one unit
    function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W-1:0] base,
                                                  input logic [LEN_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/disk_elevator_request_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel | valid    | stall     | payload
// --------+----------+-----------+--------------------------------------------------
// in      | in_valid | in_stall  | command unit is_write request_tag start_track
//         |          |           | start_sector sector_count
// out     | out_valid| out_stall | status head_valid head_tag head_is_write
//         |          |           | head_track head_sector head_count
//
// an enqueue walks the queue of its unit to find the insertion slot; the walk reads one
// entry a cycle through the single read port of the entry memory while it shifts the
// tail up by one slot through the write port. a dequeue reads the head entry of its unit,
// a rejected or empty request goes straight to its result; the sequencer returns to idle
// after each result enters the output register, before the next transfer.
// rst_n clears the queue lengths and head pointers; the entry memory is not cleared.
// in_stall is high while an item is in work; a stalled result is held in the
// output register while the next item may be accepted and worked on.

module disk_elevator_request_queue
    import derq_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         in_valid,
    output logic        in_stall,
    input  wire         command,
    input  wire  [1:0]  unit,
    input  wire         is_write,
    input  wire  [7:0]  request_tag,
    input  wire  [9:0]  start_track,
    input  wire  [3:0]  start_sector,
    input  wire  [7:0]  sector_count,

    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  status,
    output logic        head_valid,
    output logic [7:0]  head_tag,
    output logic        head_is_write,
    output logic [9:0]  head_track,
    output logic [3:0]  head_sector,
    output logic [7:0]  head_count
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_START   = 3'd1;
    localparam logic [2:0] S_WALK    = 3'd2;
    localparam logic [2:0] S_DQ_RD   = 3'd3;
    localparam logic [2:0] S_DQ_DATA = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_reg  [DISK_UNITS];
    logic [LEN_W-1:0] len_next [DISK_UNITS];
    logic [PTR_W-1:0] head_reg [DISK_UNITS];
    logic [PTR_W-1:0] head_next[DISK_UNITS];

    logic [1:0]       unit_reg, unit_next;
    entry_t           req_reg, req_next;
    entry_t           carry_reg, carry_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [9:0]       prev_reg, prev_next;
    logic             up_reg, up_next;
    logic             phase_b_reg, phase_b_next;
    logic             found_reg, found_next;

    logic [1:0]       res_status_reg, res_status_next;
    logic             res_hv_reg, res_hv_next;
    entry_t           res_entry_reg, res_entry_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_hv_reg, out_hv_next;
    entry_t           out_entry_reg, out_entry_next;

    // entry memory and its ports
    entry_t           mem [DISK_UNITS][QUEUE_DEPTH];
    entry_t           mem_rd_q;
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic             wr_en;
    entry_t           wr_data;
    logic [LEN_W-1:0] rd_idx;

    logic [UNIT_W-1:0] u_idx;
    logic [UNIT_W-1:0] in_u_idx;
    logic              in_unit_ok;
    logic [LEN_W-1:0]  len_cur;
    logic [LEN_W-1:0]  in_len;
    logic              load_out;
    logic              stop;
    logic              pb_eff;
    entry_t            new_req;

    assign u_idx    = unit_reg[UNIT_W-1:0];
    assign in_u_idx = unit[UNIT_W-1:0];
    assign len_cur  = len_reg[u_idx];
    assign in_unit_ok = {1'b0, unit} < 3'(DISK_UNITS);
    assign in_len   = in_unit_ok ? len_reg[in_u_idx] : '0;

    assign new_req.tag      = request_tag;
    assign new_req.is_write = is_write;
    assign new_req.track    = start_track;
    assign new_req.sector   = start_sector;
    assign new_req.count    = sector_count;

    // read one position ahead of the walk so data arrives as it is needed
    assign rd_idx = (state_reg == S_WALK) ? idx_reg + LEN_W'(1) : '0;
    assign rd_ptr = wrap_ptr(head_reg[u_idx], rd_idx);
    assign wr_ptr = wrap_ptr(head_reg[u_idx], idx_reg);

    always_ff @(posedge clk)
    begin
        mem_rd_q <= mem[u_idx][rd_ptr];
        if (wr_en)
        begin
            mem[u_idx][wr_ptr] <= wr_data;
        end
    end

    // insertion stop test for the element under the walk
    always_comb
    begin
        pb_eff = phase_b_reg || (prev_reg > mem_rd_q.track);
        if (up_reg)
        begin
            stop = !((mem_rd_q.track < req_reg.track) && (mem_rd_q.track > prev_reg));
        end
        else
        begin
            stop = pb_eff && (mem_rd_q.track > req_reg.track);
        end
    end

    // output register loads when free or being taken
    assign load_out = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        head_next       = head_reg;
        unit_next       = unit_reg;
        req_next        = req_reg;
        carry_next      = carry_reg;
        idx_next        = idx_reg;
        prev_next       = prev_reg;
        up_next         = up_reg;
        phase_b_next    = phase_b_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_hv_next     = res_hv_reg;
        res_entry_next  = res_entry_reg;
        wr_en           = 1'b0;
        wr_data         = req_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unit_next       = unit;
                    req_next        = new_req;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    phase_b_next    = 1'b0;
                    res_status_next = ST_OK;
                    res_hv_next     = 1'b0;
                    res_entry_next  = '0;
                    if (!in_unit_ok)
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_FINISH;
                    end
                    else if (command == CMD_DEQUEUE)
                    begin
                        if (in_len == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_DQ_RD;
                        end
                    end
                    else if (sector_count == '0)
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_FINISH;
                    end
                    else if (in_len >= LEN_W'(QUEUE_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end

            S_START:
            begin
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (idx_reg == len_cur)
                begin
                    // end of queue: last displaced entry or the new one lands here
                    wr_en          = 1'b1;
                    wr_data        = found_reg ? carry_reg : req_reg;
                    len_next[u_idx] = len_cur + LEN_W'(1);
                    state_next     = S_FINISH;
                end
                else if (idx_reg == '0)
                begin
                    // head entry sets the direction of the search
                    up_next   = req_reg.track > mem_rd_q.track;
                    prev_next = mem_rd_q.track;
                    idx_next  = LEN_W'(1);
                end
                else
                begin
                    if (found_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = carry_reg;
                        carry_next = mem_rd_q;
                    end
                    else if (stop)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = req_reg;
                        carry_next = mem_rd_q;
                        found_next = 1'b1;
                    end
                    if (!up_reg && pb_eff)
                    begin
                        phase_b_next = 1'b1;
                    end
                    prev_next = mem_rd_q.track;
                    idx_next  = idx_reg + LEN_W'(1);
                end
            end

            S_DQ_RD:
            begin
                state_next = S_DQ_DATA;
            end

            S_DQ_DATA:
            begin
                res_status_next  = ST_OK;
                res_hv_next      = 1'b1;
                res_entry_next   = mem_rd_q;
                head_next[u_idx] = wrap_ptr(head_reg[u_idx], LEN_W'(1));
                len_next[u_idx]  = len_cur - LEN_W'(1);
                state_next       = S_FINISH;
            end

            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = load_out || (out_valid_reg && out_stall);
        out_status_next = out_status_reg;
        out_hv_next     = out_hv_reg;
        out_entry_next  = out_entry_reg;
        if (load_out)
        begin
            out_status_next = res_status_reg;
            out_hv_next     = res_hv_reg;
            out_entry_next  = res_entry_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DISK_UNITS; i++)
            begin
                len_reg[i]  <= '0;
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            head_reg      <= head_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        unit_reg       <= unit_next;
        req_reg        <= req_next;
        carry_reg      <= carry_next;
        idx_reg        <= idx_next;
        prev_reg       <= prev_next;
        up_reg         <= up_next;
        phase_b_reg    <= phase_b_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_hv_reg     <= res_hv_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_hv_reg     <= out_hv_next;
        out_entry_reg  <= out_entry_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign head_valid    = out_hv_reg;
    assign head_tag      = out_entry_reg.tag;
    assign head_is_write = out_entry_reg.is_write;
    assign head_track    = out_entry_reg.track;
    assign head_sector   = out_entry_reg.sector;
    assign head_count    = out_entry_reg.count;

    // checks
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (idx_reg <= len_cur))
        else $error("insertion walk past queue length");

    a_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && head_valid) |-> (status == ST_OK))
        else $error("dequeued request with non-ok status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("sequencer idle after a transfer");

    a_dq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DQ_DATA) |-> (len_cur != '0))
        else $error("dequeue from empty queue");

endmodule

`default_nettype wire

[tb/disk_elevator_request_queue_tb.sv]
`timescale 1ns / 1ps

module disk_elevator_request_queue_tb;
    import derq_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_ITEMS    = 1700;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int TIMEOUT_NS      = 8_000_000;

    // one item on the input channel
    typedef struct packed {
        logic       cmd;
        logic [1:0] unit;
        logic       is_write;
        logic [7:0] tag;
        logic [9:0] track;
        logic [3:0] sector;
        logic [7:0] count;
    } request_t;

    // one item on the output channel
    typedef struct packed {
        logic [1:0] status;
        logic       head_valid;
        logic [7:0] tag;
        logic       is_write;
        logic [9:0] track;
        logic [3:0] sector;
        logic [7:0] count;
    } reply_t;

    // per-unit elevator queues and the replies still owed by the block
    class elevator_tracker;
        entry_t unit_queue[DISK_UNITS][$];
        reply_t replies_due[$];
        int     mismatches;
        int     checked;
        int     stored;
        int     popped;
        int     tally[4];

        function new();
            mismatches = 0;
            checked    = 0;
            stored     = 0;
            popped     = 0;
            foreach (tally[i])
                tally[i] = 0;
        endfunction

        // position of a new request in circular-scan order
        function int insert_slot(int u, logic [9:0] trk);
            int len;
            int lead;
            len  = unit_queue[u].size();
            lead = 1;
            if (len == 0)
                return 0;
            if (trk > unit_queue[u][0].track)
            begin
                // stay inside the first ascending run
                while (lead < len && unit_queue[u][lead].track < trk &&
                       unit_queue[u][lead].track > unit_queue[u][lead-1].track)
                    lead++;
            end
            else
            begin
                // skip the first run, then the wrapped entries at or below
                while (lead < len && unit_queue[u][lead-1].track <= unit_queue[u][lead].track)
                    lead++;
                while (lead < len && unit_queue[u][lead].track <= trk)
                    lead++;
            end
            return lead;
        endfunction

        function void note_request(request_t rq);
            reply_t rp;
            entry_t e;
            rp        = '0;
            rp.status = ST_OK;
            if (rq.unit >= DISK_UNITS)
            begin
                rp.status = ST_INVALID;
            end
            else if (rq.cmd == CMD_ENQUEUE)
            begin
                if (rq.count == 8'd0)
                    rp.status = ST_INVALID;
                else if (unit_queue[rq.unit].size() >= QUEUE_DEPTH)
                    rp.status = ST_FULL;
                else
                begin
                    e.tag      = rq.tag;
                    e.is_write = rq.is_write;
                    e.track    = rq.track;
                    e.sector   = rq.sector;
                    e.count    = rq.count;
                    unit_queue[rq.unit].insert(insert_slot(rq.unit, rq.track), e);
                    stored++;
                end
            end
            else if (unit_queue[rq.unit].size() == 0)
            begin
                rp.status = ST_EMPTY;
            end
            else
            begin
                e             = unit_queue[rq.unit].pop_front();
                rp.head_valid = 1'b1;
                rp.tag        = e.tag;
                rp.is_write   = e.is_write;
                rp.track      = e.track;
                rp.sector     = e.sector;
                rp.count      = e.count;
                popped++;
            end
            tally[rp.status]++;
            replies_due.push_back(rp);
        endfunction

        function void compare_field(string field, logic [9:0] want, logic [9:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $error("result with no request outstanding: status %0d", got.status);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            checked++;
            compare_field("status", 10'(want.status), 10'(got.status));
            compare_field("head_valid", 10'(want.head_valid), 10'(got.head_valid));
            compare_field("head_tag", 10'(want.tag), 10'(got.tag));
            compare_field("head_is_write", 10'(want.is_write), 10'(got.is_write));
            compare_field("head_track", want.track, got.track);
            compare_field("head_sector", 10'(want.sector), 10'(got.sector));
            compare_field("head_count", 10'(want.count), 10'(got.count));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       command;
    logic [1:0] unit;
    logic       is_write;
    logic [7:0] request_tag;
    logic [9:0] start_track;
    logic [3:0] start_sector;
    logic [7:0] sector_count;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic       head_valid;
    logic [7:0] head_tag;
    logic       head_is_write;
    logic [9:0] head_track;
    logic [3:0] head_sector;
    logic [7:0] head_count;

    elevator_tracker board;
    int  items_sent;
    int  hold_offs;
    bit  calm;
    bit  hold_off_req;

    disk_elevator_request_queue dut (.*);

    // clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // track spreads: full range, crowded low tracks, extremes, a narrow band
    function automatic logic [9:0] pick_track(int style);
        logic [9:0] t;
        case (style)
            0: t = 10'($urandom_range(0, 1023));
            1: t = 10'($urandom_range(0, 7));
            2:
            begin
                t = 10'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1)
                    t = t + 10'd1022;
            end
            default: t = 10'($urandom_range(500, 520));
        endcase
        return t;
    endfunction

    function automatic request_t make_enqueue(int u, logic [7:0] tag, logic wr,
                                              logic [9:0] trk, logic [3:0] sec,
                                              logic [7:0] cnt);
        request_t rq;
        rq.cmd      = CMD_ENQUEUE;
        rq.unit     = 2'(u);
        rq.is_write = wr;
        rq.tag      = tag;
        rq.track    = trk;
        rq.sector   = sec;
        rq.count    = cnt;
        return rq;
    endfunction

    function automatic request_t random_enqueue(int u, int style);
        logic [7:0] cnt;
        cnt = ($urandom_range(0, 24) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        return make_enqueue(u, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            pick_track(style), 4'($urandom_range(0, 15)), cnt);
    endfunction

    // the request fields of a dequeue carry random junk
    function automatic request_t make_dequeue(int u);
        request_t rq;
        rq      = random_enqueue(u, 0);
        rq.cmd  = CMD_DEQUEUE;
        rq.count = 8'($urandom_range(0, 255));
        return rq;
    endfunction

    // offer one item and wait for its transfer
    task automatic send_request(request_t rq);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        command      <= rq.cmd;
        unit         <= rq.unit;
        is_write     <= rq.is_write;
        request_tag  <= rq.tag;
        start_track  <= rq.track;
        start_sector <= rq.sector;
        sector_count <= rq.count;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
    endtask

    // transfers on both channels, results checked before new requests noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
                board.check_reply({status, head_valid, head_tag, head_is_write,
                                   head_track, head_sector, head_count});
            if (in_valid === 1'b1 && in_stall === 1'b0)
                board.note_request({command, unit, is_write, request_tag,
                                    start_track, start_sector, sector_count});
        end
    end

    // result side back-pressure
    initial
    begin : result_sink
        int stall_len;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                hold_off_req = 1'b0;
                hold_offs++;
            end
            else if (calm)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                stall_len = pick_gap();
                repeat (stall_len)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                repeat ($urandom_range(1, 8))
                begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog
    initial
    begin : watchdog
        #TIMEOUT_NS;
        $display("disk_elevator_request_queue_tb failed");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        request_t rq;
        int burst;
        int n;
        int m;
        int u;
        int style;
        int random_start;

        board        = new();
        items_sent   = 0;
        hold_offs    = 0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_ENQUEUE;
        unit         = 2'd0;
        is_write     = 1'b0;
        request_tag  = 8'd0;
        start_track  = 10'd0;
        start_sector = 4'd0;
        sector_count = 8'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queue, zero count, units out of range
        send_request(make_dequeue(0));
        send_request(make_enqueue(0, 8'd255, 1'b1, 10'd1023, 4'd15, 8'd0));
        send_request(make_enqueue(2, 8'd17, 1'b0, 10'd300, 4'd3, 8'd9));
        send_request(make_dequeue(3));

        // ascending run, wrapped run and equal tracks on unit 0
        send_request(make_enqueue(0, 8'd0, 1'b0, 10'd500, 4'd0, 8'd255));
        send_request(make_enqueue(0, 8'd255, 1'b1, 10'd800, 4'd15, 8'd1));
        send_request(make_enqueue(0, 8'd1, 1'b0, 10'd650, 4'd7, 8'd128));
        send_request(make_enqueue(0, 8'd2, 1'b1, 10'd200, 4'd8, 8'd2));
        send_request(make_enqueue(0, 8'd3, 1'b0, 10'd0, 4'd1, 8'd127));
        send_request(make_enqueue(0, 8'd4, 1'b1, 10'd1023, 4'd14, 8'd64));
        send_request(make_enqueue(0, 8'd5, 1'b0, 10'd500, 4'd2, 8'd3));
        send_request(make_enqueue(0, 8'd6, 1'b1, 10'd200, 4'd4, 8'd5));

        // fill unit 0 and push once more into the full queue
        repeat (QUEUE_DEPTH - 8)
        begin
            rq = random_enqueue(0, 0);
            if (rq.count == 8'd0)
                rq.count = 8'd1;
            send_request(rq);
        end
        send_request(make_enqueue(0, 8'd99, 1'b1, 10'd42, 4'd9, 8'd10));
        send_request(make_dequeue(0));
        send_request(make_dequeue(0));

        // random bursts: mostly enqueue runs then dequeues, some junk items
        random_start = items_sent;
        burst        = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if (burst == 15 || burst == 90)
            begin
                // long receiver hold-off while requests keep coming
                hold_off_req = 1'b1;
                repeat (12) send_request(random_enqueue($urandom_range(0, DISK_UNITS - 1), 0));
            end
            m = $urandom_range(0, 99);
            if (m < 70)
            begin
                u     = $urandom_range(0, DISK_UNITS - 1);
                style = $urandom_range(0, 3);
                n     = $urandom_range(1, 18);
                repeat (n) send_request(random_enqueue(u, style));
                repeat ($urandom_range(n / 2, n + 3)) send_request(make_dequeue(u));
            end
            else if (m < 85)
            begin
                repeat ($urandom_range(1, 20))
                    send_request(make_dequeue($urandom_range(0, DISK_UNITS - 1)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    rq     = random_enqueue($urandom_range(0, 3), 0);
                    rq.cmd = 1'($urandom_range(0, 1));
                    send_request(rq);
                end
            end
            burst++;
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // let every owed result arrive, then watch for strays
        while (board.replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests: %0d stored, %0d heads returned, %0d rejected, %0d full, %0d empty",
                 items_sent, board.stored, board.popped, board.tally[ST_INVALID],
                 board.tally[ST_FULL], board.tally[ST_EMPTY]);
        $display("%0d results checked across %0d long receiver hold-offs",
                 board.checked, hold_offs);
        if (board.mismatches == 0)
            $display("disk_elevator_request_queue_tb passed");
        else
            $display("disk_elevator_request_queue_tb failed");
        $finish;
    end

endmodule
